>>> design/second_order_state_transition_top_macros.svh
// assertion macros for the second order state transition block
`ifndef SECOND_ORDER_STATE_TRANSITION_TOP_MACROS_SVH
`define SECOND_ORDER_STATE_TRANSITION_TOP_MACROS_SVH
// property checked on every rising clock edge outside reset
`define SOST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked on every edge, also during reset
`define SOST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> design/sost_pkg.sv
// package: constants, codes and arithmetic helpers of the state transition block
`timescale 1ns / 1ps
package sost_pkg;
  localparam int MaxOutputs     = 16;
  localparam int MaxStates      = 8;
  localparam int MaxInnovations = 4;

  localparam int RW = $clog2(MaxOutputs);
  localparam int NW = $clog2(MaxStates + 1);
  localparam int QW = $clog2(MaxInnovations + 1);
  localparam int SW = (MaxStates > 1) ? $clog2(MaxStates) : 1;
  localparam int KW = (MaxInnovations > 1) ? $clog2(MaxInnovations) : 1;

  localparam int DGx  = MaxOutputs * MaxStates;
  localparam int DGu  = MaxOutputs * MaxInnovations;
  localparam int DGxx = MaxOutputs * MaxStates * MaxStates;
  localparam int DGuu = MaxOutputs * MaxInnovations * MaxInnovations;
  localparam int DGxu = MaxOutputs * MaxStates * MaxInnovations;
  localparam int AW   = 10;

  typedef enum logic [1:0] {
    CMD_COEF = 2'd0, CMD_PART = 2'd1, CMD_COMP = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [2:0] SEL_CONST = 3'd0;
  localparam logic [2:0] SEL_SS    = 3'd1;
  localparam logic [2:0] SEL_GX    = 3'd2;
  localparam logic [2:0] SEL_GU    = 3'd3;
  localparam logic [2:0] SEL_GXX   = 3'd4;
  localparam logic [2:0] SEL_GUU   = 3'd5;
  localparam logic [2:0] SEL_GXU   = 3'd6;
  localparam logic [2:0] SEL_X     = 3'd0;
  localparam logic [2:0] SEL_P     = 3'd1;
  localparam logic [2:0] SEL_E     = 3'd2;

  localparam logic [1:0] CFG_M = 2'd0;
  localparam logic [1:0] CFG_N = 2'd1;
  localparam logic [1:0] CFG_Q = 2'd2;
  localparam logic [1:0] CFG_P = 2'd3;

  typedef struct packed {
    logic [RW-1:0]        variable_index;
    logic signed [31:0]   next_value;
    logic signed [31:0]   pruned_value;
    logic                 last_of_run;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fffffff;
    else if (v < -65'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] pair_rnd(input logic signed [63:0] p,
                                                  input logic diag);
    logic signed [64:0] s;
    if (diag) s = 65'(p >>> 17) + 65'({1'b0, p[16]});
    else s = 65'(p >>> 16) + 65'({1'b0, p[15]});
    return sat32(s);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic logic signed [31:0] finish(input logic signed [63:0] a);
    return sat32(65'(a >>> 16) + 65'({1'b0, a[15]}));
  endfunction
endpackage

>>> design/sost_if.sv
// valid/ready channel interface carrying one word
`timescale 1ns / 1ps
interface sost_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/sost_ram.sv
// generic single-port write, single-port read ram with registered read
`timescale 1ns / 1ps
module sost_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/second_order_state_transition_top.sv
// Second order state transition: loads (cmd 0, cmd 1) are taken only in the idle state.
// A compute word sweeps every output variable r through a pair multiplier and a gain multiplier:
// for each r the sequencer issues n + q + n(n+1)/2 + q(q+1)/2 + nq gain terms
// (plus n + q pruned terms when pruning is on), each passing the states pair
// product, gain product and accumulate. A phase with an empty loop is skipped
// in the pair state, row by row for the cross phase when q is zero. Each variable
// also passes a state to load its constant, one to finish and one to hand off
// the result, and the compute word itself starts the sweep from idle.
// Coefficient memories have one read port each, all driven by one shared read address.
// Results leave through a one-word output register; the sweep stalls while it is full.
`timescale 1ns / 1ps
`include "second_order_state_transition_top_macros.svh"
module second_order_state_transition_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_table_select,
  input  logic [9:0]  in_element_index,
  input  logic signed [31:0] in_element_value,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [3:0]  out_variable_index,
  output logic signed [31:0] out_next_value,
  output logic signed [31:0] out_pruned_value,
  output logic        out_last_of_run,
  output logic        out_valid,
  input  logic        out_ready
);
  import sost_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ROW, S_PAIR, S_GAIN, S_ACC, S_FIN, S_OUT} st_t;
  typedef enum logic [2:0] {T_LX, T_LU, T_XX, T_UU, T_XU, T_PX, T_PU} ph_t;

  logic [4:0] m_r; logic [3:0] n_r; logic [2:0] q_r; logic p_r;
  st_t st_r; ph_t ph_r;
  logic [RW-1:0] row_r;
  logic [SW-1:0] i_r, j_r;
  logic [AW-1:0] addr_r;
  logic signed [63:0] acc_r, acc1_r, prod_r;
  logic signed [31:0] pairv_r;
  logic [31:0] xs [MaxStates];
  logic [31:0] ps [MaxStates];
  logic [31:0] es [MaxInnovations];
  logic ov_r; res_t res_r;

  logic [4:0] m_e; logic [3:0] n_e; logic [2:0] q_e;
  assign m_e = (m_r > 5'(MaxOutputs)) ? 5'(MaxOutputs) : m_r;
  assign n_e = (n_r > 4'(MaxStates)) ? 4'(MaxStates) : n_r;
  assign q_e = (q_r > 3'(MaxInnovations)) ? 3'(MaxInnovations) : q_r;

  logic acc_in;
  assign acc_in = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE);

  // coefficient memories
  logic we_c, we_s, we_gx, we_gu, we_gxx, we_guu, we_gxu;
  logic [31:0] rd_c, rd_s, rd_gx, rd_gu, rd_gxx, rd_guu, rd_gxu;
  logic [AW-1:0] ra;
  logic coef;
  assign coef = acc_in && in_cmd == CMD_COEF;
  assign we_c   = coef && in_table_select == SEL_CONST && in_element_index < 10'(MaxOutputs);
  assign we_s   = coef && in_table_select == SEL_SS && in_element_index < 10'(MaxOutputs);
  assign we_gx  = coef && in_table_select == SEL_GX && in_element_index < 10'(DGx);
  assign we_gu  = coef && in_table_select == SEL_GU && in_element_index < 10'(DGu);
  assign we_gxx = coef && in_table_select == SEL_GXX && 11'(in_element_index) < 11'(DGxx);
  assign we_guu = coef && in_table_select == SEL_GUU && in_element_index < 10'(DGuu);
  assign we_gxu = coef && in_table_select == SEL_GXU && in_element_index < 10'(DGxu);
  assign ra = addr_r;

  sost_ram #(.W(32), .D(MaxOutputs)) u_c (.clk, .we(we_c),
    .waddr(in_element_index[$clog2(MaxOutputs)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(MaxOutputs)-1:0]), .rdata(rd_c));
  sost_ram #(.W(32), .D(MaxOutputs)) u_s (.clk, .we(we_s),
    .waddr(in_element_index[$clog2(MaxOutputs)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(MaxOutputs)-1:0]), .rdata(rd_s));
  sost_ram #(.W(32), .D(DGx)) u_gx (.clk, .we(we_gx),
    .waddr(in_element_index[$clog2(DGx)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(DGx)-1:0]), .rdata(rd_gx));
  sost_ram #(.W(32), .D(DGu)) u_gu (.clk, .we(we_gu),
    .waddr(in_element_index[$clog2(DGu)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(DGu)-1:0]), .rdata(rd_gu));
  sost_ram #(.W(32), .D(DGxx)) u_gxx (.clk, .we(we_gxx),
    .waddr(in_element_index[$clog2(DGxx)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(DGxx)-1:0]), .rdata(rd_gxx));
  sost_ram #(.W(32), .D(DGuu)) u_guu (.clk, .we(we_guu),
    .waddr(in_element_index[$clog2(DGuu)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(DGuu)-1:0]), .rdata(rd_guu));
  sost_ram #(.W(32), .D(DGxu)) u_gxu (.clk, .we(we_gxu),
    .waddr(in_element_index[$clog2(DGxu)-1:0]), .wdata(in_element_value),
    .raddr(ra[$clog2(DGxu)-1:0]), .rdata(rd_gxu));

  // particle vectors
  always_ff @(posedge clk) begin
    if (acc_in && in_cmd == CMD_PART) begin
      if (in_table_select == SEL_X && in_element_index < 10'(MaxStates))
        xs[in_element_index[SW-1:0]] <= in_element_value;
      if (in_table_select == SEL_P && in_element_index < 10'(MaxStates))
        ps[in_element_index[SW-1:0]] <= in_element_value;
      if (in_table_select == SEL_E && in_element_index < 10'(MaxInnovations))
        es[in_element_index[KW-1:0]] <= in_element_value;
    end
  end

  // term operands for current phase
  logic [31:0] fa, fb, gsel;
  logic dg, lin;
  logic [31:0] zi;
  always_comb begin
    zi = p_r ? ps[i_r] : xs[i_r];
    fa = 32'd0; fb = 32'd0; dg = 1'b0; lin = 1'b1; gsel = rd_gx;
    unique case (ph_r)
      T_LX: begin fa = xs[j_r]; gsel = rd_gx; end
      T_LU: begin fa = es[j_r[KW-1:0]]; gsel = rd_gu; end
      T_XX: begin lin = 1'b0; fa = zi; fb = p_r ? ps[j_r] : xs[j_r];
        dg = (i_r == j_r); gsel = rd_gxx; end
      T_UU: begin lin = 1'b0; fa = es[i_r[KW-1:0]]; fb = es[j_r[KW-1:0]];
        dg = (i_r == j_r); gsel = rd_guu; end
      T_XU: begin lin = 1'b0; fa = zi; fb = es[j_r[KW-1:0]]; gsel = rd_gxu; end
      T_PX: begin fa = ps[j_r]; gsel = rd_gx; end
      T_PU: begin fa = es[j_r[KW-1:0]]; gsel = rd_gu; end
      default: ;
    endcase
  end

  // step to next term: returns done flag
  logic [SW-1:0] ni, nj; ph_t nph; logic nend;
  logic [AW-1:0] naddr;
  always_comb begin
    ni = i_r; nj = j_r; nph = ph_r; nend = 1'b0;
    unique case (ph_r)
      T_LX: if (5'(j_r) + 5'd1 < 5'(n_e)) nj = j_r + 1'b1;
            else begin nph = T_LU; nj = '0; end
      T_LU: if (5'(j_r) + 5'd1 < 5'(q_e)) nj = j_r + 1'b1;
            else begin nph = T_XX; ni = '0; nj = '0; end
      T_XX: if (5'(j_r) + 5'd1 < 5'(n_e)) nj = j_r + 1'b1;
            else if (5'(i_r) + 5'd1 < 5'(n_e)) begin ni = i_r + 1'b1; nj = i_r + 1'b1; end
            else begin nph = T_UU; ni = '0; nj = '0; end
      T_UU: if (5'(j_r) + 5'd1 < 5'(q_e)) nj = j_r + 1'b1;
            else if (5'(i_r) + 5'd1 < 5'(q_e)) begin ni = i_r + 1'b1; nj = i_r + 1'b1; end
            else begin nph = T_XU; ni = '0; nj = '0; end
      T_XU: if (5'(j_r) + 5'd1 < 5'(q_e)) nj = j_r + 1'b1;
            else if (5'(i_r) + 5'd1 < 5'(n_e)) begin ni = i_r + 1'b1; nj = '0; end
            else if (p_r) begin nph = T_PX; ni = '0; nj = '0; end
            else nend = 1'b1;
      T_PX: if (5'(j_r) + 5'd1 < 5'(n_e)) nj = j_r + 1'b1;
            else begin nph = T_PU; nj = '0; end
      T_PU: if (5'(j_r) + 5'd1 < 5'(q_e)) nj = j_r + 1'b1;
            else nend = 1'b1;
      default: nend = 1'b1;
    endcase
    // column-major address row + col*m
    unique case (nph)
      T_LX, T_PX, T_LU, T_PU: naddr = AW'(32'(row_r) + 32'(nj) * 32'(m_e));
      T_XX: naddr = AW'(32'(row_r) + (32'(ni) * 32'(n_e) + 32'(nj)) * 32'(m_e));
      default: naddr = AW'(32'(row_r) + (32'(ni) * 32'(q_e) + 32'(nj)) * 32'(m_e));
    endcase
  end

  logic skip;
  assign skip = (ph_r == T_LX && n_e == 4'd0) || (ph_r == T_LU && q_e == 3'd0)
    || ((ph_r == T_XX || ph_r == T_XU || ph_r == T_PX) && n_e == 4'd0)
    || ((ph_r == T_UU || ph_r == T_XU || ph_r == T_PU) && q_e == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= 5'd1; n_r <= 4'd1; q_r <= 3'd1; p_r <= 1'b0;
      st_r <= S_IDLE; ov_r <= 1'b0; ph_r <= T_LX;
      row_r <= '0; i_r <= '0; j_r <= '0; addr_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_M: m_r <= cfg_data;
          CFG_N: n_r <= cfg_data[3:0];
          CFG_Q: q_r <= cfg_data[2:0];
          CFG_P: p_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (acc_in && in_cmd == CMD_COMP && m_e != 5'd0) begin
          row_r <= '0; addr_r <= '0; st_r <= S_ROW;
        end
        S_ROW: begin
          // constant and steady reads land now
          acc_r <= 64'(signed'(rd_c)) <<< 16;
          acc1_r <= 64'(signed'(rd_s)) <<< 16;
          ph_r <= T_LX; i_r <= '0; j_r <= '0;
          addr_r <= AW'(row_r);
          st_r <= S_PAIR;
        end
        S_PAIR: begin
          // wait cycle for gain read; form pair product
          if (skip) begin
            if (nend) st_r <= S_FIN;
            else begin
              ph_r <= nph; i_r <= ni; j_r <= nj; addr_r <= naddr;
            end
          end else begin
            pairv_r <= lin ? fa : pair_rnd(signed'(fa) * signed'(fb), dg);
            st_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          prod_r <= signed'(gsel) * pairv_r;
          st_r <= S_ACC;
        end
        S_ACC: begin
          if (ph_r == T_PX || ph_r == T_PU) acc1_r <= sat_add(acc1_r, prod_r);
          else acc_r <= sat_add(acc_r, prod_r);
          if (nend) st_r <= S_FIN;
          else begin
            ph_r <= nph; i_r <= ni; j_r <= nj; addr_r <= naddr; st_r <= S_PAIR;
          end
        end
        S_FIN: if (!ov_r) begin
          res_r.variable_index <= row_r;
          res_r.next_value <= finish(acc_r);
          res_r.pruned_value <= p_r ? finish(acc1_r) : 32'sd0;
          res_r.last_of_run <= (5'(row_r) + 5'd1 == m_e);
          ov_r <= 1'b1;
          // point the constant read at the next row
          addr_r <= (5'(row_r) + 5'd1 == m_e) ? '0 : AW'(row_r) + 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (5'(row_r) + 5'd1 == m_e) st_r <= S_IDLE;
          else begin
            row_r <= row_r + 1'b1; st_r <= S_ROW;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_variable_index = 4'(res_r.variable_index);
  assign out_next_value = res_r.next_value;
  assign out_pruned_value = res_r.pruned_value;
  assign out_last_of_run = res_r.last_of_run;

  `SOST_ASSERT(a_ready_idle, in_ready |-> st_r == S_IDLE, "ready outside idle")
  `SOST_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid && $stable(out_next_value), "result dropped")
  `SOST_ASSERT(a_row_range, st_r != S_IDLE |-> 5'(row_r) < m_e, "row beyond output count")
  `SOST_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "valid after reset")
endmodule

>>> dv/second_order_state_transition_top_tb.sv
// testbench for second_order_state_transition_top: random loads and computes checked by a scoreboard
`timescale 1ns / 1ps
module second_order_state_transition_top_tb;
  import sost_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int DrainWait  = 16;
  localparam int CycleLimit = 20000000;
  localparam int RandItems  = 410;

  typedef struct packed {
    cmd_t               cmd;
    logic [2:0]         sel;
    logic [9:0]         idx;
    logic signed [31:0] val;
  } in_word_t;

  class transition_scoreboard;
    logic [4:0] cfg_m;
    logic [3:0] cfg_n;
    logic [2:0] cfg_q;
    logic       cfg_p;
    logic signed [31:0] cst[MaxOutputs], ss[MaxOutputs], gx[DGx], gu[DGu];
    logic signed [31:0] gxx[DGxx], guu[DGuu], gxu[DGxu];
    logic signed [31:0] xs[MaxStates], ps[MaxStates], es[MaxInnovations];
    bit w_cst[MaxOutputs], w_ss[MaxOutputs], w_gx[DGx], w_gu[DGu];
    bit w_gxx[DGxx], w_guu[DGuu], w_gxu[DGxu];
    bit w_xs[MaxStates], w_ps[MaxStates], w_es[MaxInnovations];
    res_t expected_results[$];
    int   errors;
    int   results_seen;
    int   computes;

    function new();
      cfg_m = 1; cfg_n = 1; cfg_q = 1; cfg_p = 0;
      errors = 0; results_seen = 0; computes = 0;
    endfunction

    function void set_cfg(logic [1:0] index, logic [4:0] data);
      case (index)
        CFG_M: cfg_m = data;
        CFG_N: cfg_n = data[3:0];
        CFG_Q: cfg_q = data[2:0];
        CFG_P: cfg_p = data[0];
        default: ;
      endcase
    endfunction

    function int eff_m();
      return (cfg_m > MaxOutputs) ? MaxOutputs : cfg_m;
    endfunction
    function int eff_n();
      return (cfg_n > MaxStates) ? MaxStates : cfg_n;
    endfunction
    function int eff_q();
      return (cfg_q > MaxInnovations) ? MaxInnovations : cfg_q;
    endfunction

    function longint mulw(logic signed [31:0] a, logic signed [31:0] b);
      return longint'(a) * longint'(b);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] round_to_q16(longint v, int k);
      longint f;
      f = (v >>> k) + ((v >>> (k - 1)) & 64'sd1);
      return clip32(f);
    endfunction

    function longint acc_add(longint a, longint b);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
        s = (a < 0) ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      return s;
    endfunction

    function logic signed [31:0] pair_val(logic signed [31:0] a, logic signed [31:0] b,
                                          bit diag);
      return round_to_q16(mulw(a, b), diag ? 17 : 16);
    endfunction

    function void sweep_outputs();
      int m, n, q;
      longint acc, acc1;
      logic signed [31:0] z[MaxStates];
      res_t res;
      m = eff_m(); n = eff_n(); q = eff_q();
      computes++;
      for (int i = 0; i < MaxStates; i++) z[i] = cfg_p ? ps[i] : xs[i];
      for (int r = 0; r < m; r++) begin
        acc = mulw(cst[r], 32'sd65536);
        acc1 = mulw(ss[r], 32'sd65536);
        for (int j = 0; j < n; j++) acc = acc_add(acc, mulw(gx[r + j * m], xs[j]));
        for (int j = 0; j < q; j++) acc = acc_add(acc, mulw(gu[r + j * m], es[j]));
        for (int i = 0; i < n; i++)
          for (int j = i; j < n; j++)
            acc = acc_add(acc, mulw(gxx[r + (i * n + j) * m], pair_val(z[i], z[j], i == j)));
        for (int i = 0; i < q; i++)
          for (int j = i; j < q; j++)
            acc = acc_add(acc, mulw(guu[r + (i * q + j) * m], pair_val(es[i], es[j], i == j)));
        for (int i = 0; i < n; i++)
          for (int j = 0; j < q; j++)
            acc = acc_add(acc, mulw(gxu[r + (i * q + j) * m], pair_val(z[i], es[j], 0)));
        res.variable_index = r[3:0];
        res.next_value = round_to_q16(acc, 16);
        res.pruned_value = '0;
        if (cfg_p) begin
          for (int j = 0; j < n; j++) acc1 = acc_add(acc1, mulw(gx[r + j * m], ps[j]));
          for (int j = 0; j < q; j++) acc1 = acc_add(acc1, mulw(gu[r + j * m], es[j]));
          res.pruned_value = round_to_q16(acc1, 16);
        end
        res.last_of_run = (r == m - 1);
        expected_results.push_back(res);
      end
    endfunction

    function void note_input(in_word_t w);
      int i;
      i = w.idx;
      if (w.cmd == CMD_COEF) begin
        case (w.sel)
          SEL_CONST: if (i < MaxOutputs) begin cst[i] = w.val; w_cst[i] = 1; end
          SEL_SS:    if (i < MaxOutputs) begin ss[i] = w.val; w_ss[i] = 1; end
          SEL_GX:    if (i < DGx) begin gx[i] = w.val; w_gx[i] = 1; end
          SEL_GU:    if (i < DGu) begin gu[i] = w.val; w_gu[i] = 1; end
          SEL_GXX:   if (i < DGxx) begin gxx[i] = w.val; w_gxx[i] = 1; end
          SEL_GUU:   if (i < DGuu) begin guu[i] = w.val; w_guu[i] = 1; end
          SEL_GXU:   if (i < DGxu) begin gxu[i] = w.val; w_gxu[i] = 1; end
          default: ;
        endcase
      end else if (w.cmd == CMD_PART) begin
        case (w.sel)
          SEL_X: if (i < MaxStates) begin xs[i] = w.val; w_xs[i] = 1; end
          SEL_P: if (i < MaxStates) begin ps[i] = w.val; w_ps[i] = 1; end
          SEL_E: if (i < MaxInnovations) begin es[i] = w.val; w_es[i] = 1; end
          default: ;
        endcase
      end else if (w.cmd == CMD_COMP) begin
        sweep_outputs();
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word var=%0d next=%0d", $time, got.variable_index,
                 got.next_value);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.variable_index !== want.variable_index) begin
        $display("%0t: variable_index expected %0d actual %0d", $time,
                 want.variable_index, got.variable_index);
        errors++;
      end
      if (got.next_value !== want.next_value) begin
        $display("%0t: next_value var %0d expected %0d actual %0d", $time,
                 want.variable_index, want.next_value, got.next_value);
        errors++;
      end
      if (got.pruned_value !== want.pruned_value) begin
        $display("%0t: pruned_value var %0d expected %0d actual %0d", $time,
                 want.variable_index, want.pruned_value, got.pruned_value);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run var %0d expected %0b actual %0b", $time,
                 want.variable_index, want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  bit   no_idle;
  int   cycles;
  transition_scoreboard sb;

  sost_if #(.T(in_word_t)) in_if (clk);
  sost_if #(.T(res_t)) out_if (clk);

  second_order_state_transition_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cmd(in_if.data.cmd), .in_table_select(in_if.data.sel),
    .in_element_index(in_if.data.idx), .in_element_value(in_if.data.val),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_variable_index(out_if.data.variable_index),
    .out_next_value(out_if.data.next_value),
    .out_pruned_value(out_if.data.pruned_value),
    .out_last_of_run(out_if.data.last_of_run),
    .out_valid(out_if.valid), .out_ready(out_if.ready)
  );

  initial begin
    clk = 0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("second_order_state_transition_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
    out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
    endcase
  endfunction

  task automatic send_word(cmd_t cmd, logic [2:0] sel, logic [9:0] idx,
                           logic signed [31:0] val);
    in_word_t w;
    w.cmd = cmd; w.sel = sel; w.idx = idx; w.val = val;
    if (!no_idle && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    @(posedge clk iff in_if.ready);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_cfg(logic [4:0] m, logic [4:0] n, logic [4:0] q, logic [4:0] p);
    logic [4:0] vals[4];
    vals = '{m, n, q, p};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      sb.set_cfg(i[1:0], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // load every entry the next compute reads that has not been written yet
  task automatic fill_tables();
    int m, n, q, a;
    m = sb.eff_m(); n = sb.eff_n(); q = sb.eff_q();
    for (int j = 0; j < n; j++) begin
      if (!sb.w_xs[j]) send_word(CMD_PART, SEL_X, 10'(j), rand_val());
      if (sb.cfg_p && !sb.w_ps[j]) send_word(CMD_PART, SEL_P, 10'(j), rand_val());
    end
    for (int j = 0; j < q; j++)
      if (!sb.w_es[j]) send_word(CMD_PART, SEL_E, 10'(j), rand_val());
    for (int r = 0; r < m; r++) begin
      if (!sb.w_cst[r]) send_word(CMD_COEF, SEL_CONST, 10'(r), rand_val());
      if (sb.cfg_p && !sb.w_ss[r]) send_word(CMD_COEF, SEL_SS, 10'(r), rand_val());
      for (int j = 0; j < n; j++) begin
        a = r + j * m;
        if (!sb.w_gx[a]) send_word(CMD_COEF, SEL_GX, 10'(a), rand_val());
      end
      for (int j = 0; j < q; j++) begin
        a = r + j * m;
        if (!sb.w_gu[a]) send_word(CMD_COEF, SEL_GU, 10'(a), rand_val());
      end
      for (int i = 0; i < n; i++)
        for (int j = i; j < n; j++) begin
          a = r + (i * n + j) * m;
          if (!sb.w_gxx[a]) send_word(CMD_COEF, SEL_GXX, 10'(a), rand_val());
        end
      for (int i = 0; i < q; i++)
        for (int j = i; j < q; j++) begin
          a = r + (i * q + j) * m;
          if (!sb.w_guu[a]) send_word(CMD_COEF, SEL_GUU, 10'(a), rand_val());
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < q; j++) begin
          a = r + (i * q + j) * m;
          if (!sb.w_gxu[a]) send_word(CMD_COEF, SEL_GXU, 10'(a), rand_val());
        end
    end
  endtask

  task automatic compute_word();
    fill_tables();
    send_word(CMD_COMP, 3'($urandom), 10'($urandom), $urandom);
  endtask

  task automatic random_word();
    int pick, depth;
    logic [2:0] sel;
    logic [9:0] idx;
    pick = $urandom_range(99);
    if (pick < 40) begin
      compute_word();
    end else if (pick < 75) begin
      sel = 3'($urandom_range(6));
      case (sel)
        SEL_CONST, SEL_SS: depth = MaxOutputs;
        SEL_GX: depth = DGx;
        SEL_GU: depth = DGu;
        SEL_GXX: depth = DGxx;
        SEL_GUU: depth = DGuu;
        default: depth = DGxu;
      endcase
      idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(depth - 1));
      send_word(CMD_COEF, sel, idx, rand_val());
    end else if (pick < 95) begin
      sel = 3'($urandom_range(2));
      depth = (sel == SEL_E) ? MaxInnovations : MaxStates;
      idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(depth - 1));
      send_word(CMD_PART, sel, idx, rand_val());
    end else begin
      case ($urandom_range(2))
        0: send_word(CMD_NONE, 3'($urandom), 10'($urandom), $urandom);
        1: send_word(CMD_COEF, 3'd7, 10'($urandom), $urandom);
        default: send_word(CMD_PART, 3'($urandom_range(3, 7)), 10'($urandom), $urandom);
      endcase
    end
  endtask

  initial begin
    logic [4:0] phases[10][4];
    sb = new();
    cycles = 0;
    no_idle = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default settings, then largest shape with saturating values
    compute_word();
    wait_idle();
    write_cfg(5'd16, 5'd8, 5'd4, 5'd1);
    send_word(CMD_PART, SEL_X, 10'd0, 32'sh7fffffff);
    send_word(CMD_PART, SEL_P, 10'd0, 32'sh80000000);
    send_word(CMD_PART, SEL_E, 10'd0, 32'sh80000000);
    send_word(CMD_PART, SEL_E, 10'd3, 32'sh7fffffff);
    send_word(CMD_COEF, SEL_CONST, 10'd0, 32'sh7fffffff);
    send_word(CMD_COEF, SEL_GX, 10'd0, 32'sh7fffffff);
    send_word(CMD_COEF, SEL_GXX, 10'd0, 32'sh80000000);
    send_word(CMD_COEF, SEL_GXX, 10'd1023, 32'sh7fffffff);
    send_word(CMD_COEF, SEL_GUU, 10'd255, 32'sh80000000);
    send_word(CMD_COEF, SEL_GXU, 10'd511, 32'sh7fffffff);
    send_word(CMD_COEF, SEL_GX, 10'd1023, 32'sh12345678);
    send_word(CMD_PART, SEL_E, 10'd4, 32'sh7fffffff);
    send_word(CMD_COEF, 3'd7, 10'd0, 32'sh1);
    send_word(CMD_PART, 3'd3, 10'd0, 32'sh1);
    send_word(CMD_NONE, 3'd7, 10'd1023, 32'shffffffff);
    compute_word();
    send_word(CMD_PART, SEL_X, 10'd1, 32'sh80000000);
    compute_word();
    wait_idle();

    phases = '{'{1, 1, 1, 0}, '{16, 8, 4, 0}, '{0, 3, 2, 1}, '{31, 15, 7, 1},
               '{5, 0, 0, 0}, '{3, 2, 0, 1}, '{7, 8, 1, 0}, '{16, 8, 4, 1},
               '{2, 1, 4, 0}, '{0, 0, 0, 0}};
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) write_cfg(5'($urandom_range(1, 16)), 5'($urandom_range(1, 8)),
                             5'($urandom_range(1, 4)), 5'($urandom_range(1)));
      else write_cfg(phases[ph][0], phases[ph][1], phases[ph][2], phases[ph][3]);
      no_idle = (ph == 6);
      repeat (RandItems / 10) random_word();
      wait_idle();
    end
    no_idle = 0;

    $display("covered %0d compute words and %0d result words over 12 register settings",
             sb.computes, sb.results_seen);
    $display("loads hit every table, out-of-range indexes and unused selects");
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("second_order_state_transition_top_tb passed");
    end else begin
      $display("second_order_state_transition_top_tb failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/sost_pkg.sv
design/sost_if.sv
design/sost_ram.sv
design/second_order_state_transition_top.sv
dv/second_order_state_transition_top_tb.sv
